### design/lcdsm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and glyph tables for the multiplexed LCD driver.
// No dependencies; every other design file imports this package.

package lcdsm_pkg;

    // Number of digits that a rebuild packs into the COM buffers (1..4).
    localparam int DIGITS = 4;

    // Digit store and COM buffer address space (always four entries).
    localparam int STORE_DEPTH = 4;
    localparam int COM_COUNT   = 4;

    localparam int GLYPH_COUNT = 28;

    // Reset values of the timers and configuration registers.
    localparam logic [7:0] REFRESH_PERIOD_RST  = 8'd125;
    localparam logic [7:0] SCAN_PERIOD_RST     = 8'd1;
    localparam logic [7:0] REFRESH_ELAPSED_RST = 8'd124;
    localparam logic [7:0] SCAN_ELAPSED_RST    = 8'd0;

    // Blink counter values above this blank the blinking digits.
    localparam logic [2:0] BLINK_SHOW_MAX = 3'd4;

    // Decimal point lands on segment bit 6.
    localparam logic [7:0] DP_MASK = 8'h40;

    // Input item function codes.
    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_UPSIDE_DOWN    = 2'd0,
        CFG_SCAN_PERIOD    = 2'd1,
        CFG_REFRESH_PERIOD = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    // Control from the item stage to the display state.
    typedef struct packed {
        logic wr;       // store one digit
        logic rebuild;  // refresh timer fired on this tick
    } t_disp_ctl;

    localparam logic [7:0] GLYPH_NORMAL [GLYPH_COUNT] = '{
        8'hB7, 8'h22, 8'h9B, 8'hAB, 8'h2E, 8'hAD, 8'hBD, 8'h23, 8'hBF, 8'hAF,
        8'h3F, 8'hBC, 8'h95, 8'hBA, 8'h9D, 8'h1D, 8'hB5, 8'h3E, 8'hA2, 8'h94,
        8'h38, 8'hB8, 8'h1F, 8'h18, 8'h9C, 8'hB6, 8'h08, 8'h00
    };

    localparam logic [7:0] GLYPH_ROTATED [GLYPH_COUNT] = '{
        8'hB7, 8'h14, 8'h9B, 8'h9D, 8'h3C, 8'hAD, 8'hAF, 8'h94, 8'hBF, 8'hBD,
        8'hBE, 8'h2F, 8'hA3, 8'h1F, 8'hAB, 8'hAA, 8'hA7, 8'h3E, 8'h15, 8'h23,
        8'h0E, 8'h0F, 8'hBA, 8'h0A, 8'h2B, 8'h37, 8'h08, 8'h00
    };

    // Segment byte of one glyph code; codes past the table are blank.
    function automatic logic [7:0] glyph_lookup(input logic upside, input logic [4:0] code);
        logic [7:0] seg;
        seg = 8'h00;
        if (int'(code) < GLYPH_COUNT) begin
            seg = upside ? GLYPH_ROTATED[code] : GLYPH_NORMAL[code];
        end
        return seg;
    endfunction

endpackage

### design/lcdsm_glyph.sv
`timescale 1ns / 1ps
// Segment pattern of one stored digit: glyph lookup, blink blanking, point.
// Depends on lcdsm_pkg.

module lcdsm_glyph
    import lcdsm_pkg::*;
(
    input  logic [6:0] i_digit,      // {blink, dp, code}
    input  logic [2:0] i_blink_cnt,
    input  logic       i_upside,
    output logic [7:0] o_seg
);

    logic [7:0] glyph;

    assign glyph = glyph_lookup(i_upside, i_digit[4:0]);

    always_comb begin
        if (i_digit[6] && (i_blink_cnt > BLINK_SHOW_MAX)) begin
            o_seg = 8'h00;
        end else if (i_digit[5]) begin
            o_seg = glyph | DP_MASK;
        end else begin
            o_seg = glyph;
        end
    end

endmodule

### design/lcdsm_timer.sv
`timescale 1ns / 1ps
// Saturating tick counter that fires when it reaches its period.
// Depends on lcdsm_pkg.

module lcdsm_timer
    import lcdsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rst_value,
    input  logic       i_tick,
    input  logic [7:0] i_period,
    output logic       o_fire
);

    logic [7:0] r_elapsed;
    logic [7:0] n_elapsed;
    logic [8:0] sum;
    logic [7:0] count;

    // Saturate the incremented count at 255.
    assign sum   = {1'b0, r_elapsed} + 9'd1;
    assign count = sum[8] ? 8'hFF : sum[7:0];

    assign o_fire = (count >= i_period);

    always_comb begin
        n_elapsed = r_elapsed;
        if (i_tick) begin
            n_elapsed = o_fire ? 8'h00 : count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= i_rst_value;
        end else begin
            r_elapsed <= n_elapsed;
        end
    end

endmodule

### design/lcdsm_display.sv
`timescale 1ns / 1ps
// Digit store, blink counter and COM segment buffers with the rebuild logic.
// Depends on lcdsm_pkg and lcdsm_glyph.

module lcdsm_display
    import lcdsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_disp_ctl  i_ctl,
    input  logic [1:0] i_digit_index,
    input  logic [6:0] i_digit_word,
    input  logic       i_upside,
    input  logic [1:0] i_com,
    output logic [7:0] o_com_byte
);

    logic [6:0] r_store [STORE_DEPTH];
    logic [7:0] r_com_buf [COM_COUNT];
    logic [2:0] r_blink_cnt;

    logic [7:0] n_com_buf [COM_COUNT];
    logic [2:0] n_blink_cnt;
    logic [7:0] seg [DIGITS];
    logic [1:0] src [DIGITS];
    logic       wr_ok;

    assign n_blink_cnt = r_blink_cnt + 3'd1;
    assign wr_ok       = i_ctl.wr && (int'(i_digit_index) < DIGITS);

    // Normal order packs the last digit first; upside down reverses it.
    genvar gk;
    generate
        for (gk = 0; gk < DIGITS; gk++) begin : g_digit
            assign src[gk] = i_upside ? 2'(gk) : 2'(DIGITS - 1 - gk);
            lcdsm_glyph u_glyph (
                .i_digit    (r_store[src[gk]]),
                .i_blink_cnt(n_blink_cnt),
                .i_upside   (i_upside),
                .o_seg      (seg[gk])
            );
        end
    endgenerate

    // Shift two segment bits per digit into each COM byte.
    always_comb begin
        for (int j = 0; j < COM_COUNT; j++) begin
            n_com_buf[j] = r_com_buf[j];
            if (i_ctl.rebuild) begin
                for (int k = 0; k < DIGITS; k++) begin
                    n_com_buf[j] = {n_com_buf[j][5:0], seg[k][2*j +: 2]};
                end
            end
        end
    end

    // The scan reads the buffers as they stand after this item's rebuild.
    assign o_com_byte = n_com_buf[i_com];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_cnt <= 3'd0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= 7'd0;
            end
            for (int j = 0; j < COM_COUNT; j++) begin
                r_com_buf[j] <= 8'd0;
            end
        end else begin
            if (i_ctl.rebuild) begin
                r_blink_cnt <= n_blink_cnt;
            end
            if (wr_ok) begin
                r_store[i_digit_index] <= i_digit_word;
            end
            for (int j = 0; j < COM_COUNT; j++) begin
                r_com_buf[j] <= n_com_buf[j];
            end
        end
    end

endmodule

### design/lcd_seven_segment_mux_driver.sv
`timescale 1ns / 1ps
// Top level of the four-COM multiplexed LCD seven-segment driver.
// Depends on lcdsm_pkg, lcdsm_timer and lcdsm_display.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): each item is either a digit write
//   (i_func = 1: code, point and blink bits for one digit) or one timer tick
//   (i_func = 0). An item is taken at a clock edge with valid high, stall low.
//   Output channel (o_out_valid / i_out_stall): a tick on which the scan timer
//   fires yields one drive item (active COM, COM level, segment levels).
//   Writes and silent ticks yield nothing.
//   An item waits in the input register; its result is loaded into the
//   output register, from which it can be taken.
//   Throughput: one item per cycle unless stalled. The glyph lookup, blink
//   blanking, COM buffer rebuild and scan selection all finish between the
//   two registers. Stall: while the output register holds an unread item
//   and the item in the input register would produce another, hold it and
//   raise o_in_stall. Writes and silent ticks drain past a stalled output.
//   Reset (i_rst_n low, synchronous): clear the digit store, COM buffers,
//   blink counter and scan phase; load upside_down 0, scan period 1, refresh
//   period 125 and set the refresh count so that the first tick refreshes.
//   Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is to be written only
//   when idle, by the user; the block itself does not enforce this.

module lcd_seven_segment_mux_driver
    import lcdsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [1:0] i_digit_index,
    input  logic [4:0] i_char_code,
    input  logic       i_decimal_point,
    input  logic       i_blink,
    // result items
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_active_com,
    output logic       o_com_level,
    output logic [7:0] o_segments
);

    // Configuration registers.
    logic       r_upside_down;
    logic [7:0] r_scan_period;
    logic [7:0] r_refresh_period;

    // Input register.
    logic       r_s1_valid;
    logic       r_s1_func;
    logic [1:0] r_s1_digit_index;
    logic [6:0] r_s1_digit_word;

    // Scan sequence and output register.
    logic [2:0] r_scan_phase;
    logic       r_out_valid;
    logic [1:0] r_out_com;
    logic       r_out_level;
    logic [7:0] r_out_seg;

    logic       in_accept;
    logic       s1_go;
    logic       s1_has_result;
    logic       tick_en;
    logic       refresh_fire;
    logic       scan_fire;
    logic       load_out;
    logic [7:0] com_byte;
    t_disp_ctl  disp_ctl;

    // Configuration writes; the unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upside_down    <= 1'b0;
            r_scan_period    <= SCAN_PERIOD_RST;
            r_refresh_period <= REFRESH_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_UPSIDE_DOWN:    r_upside_down    <= i_cfg_data[0];
                CFG_SCAN_PERIOD:    r_scan_period    <= i_cfg_data;
                CFG_REFRESH_PERIOD: r_refresh_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A tick produces a result only when the scan timer fires. Hold the item
    // only if that result would overwrite an unread one.
    assign s1_has_result = (t_func'(r_s1_func) == FUNC_TICK) && scan_fire;
    assign s1_go         = r_s1_valid && !(r_out_valid && i_out_stall && s1_has_result);
    assign o_in_stall    = r_s1_valid && !s1_go;
    assign in_accept     = i_in_valid && !o_in_stall;
    assign tick_en       = s1_go && (t_func'(r_s1_func) == FUNC_TICK);
    assign load_out      = tick_en && scan_fire;

    assign disp_ctl.wr      = s1_go && (t_func'(r_s1_func) == FUNC_WRITE);
    assign disp_ctl.rebuild = tick_en && refresh_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func        <= i_func;
            r_s1_digit_index <= i_digit_index;
            r_s1_digit_word  <= {i_blink, i_decimal_point, i_char_code};
        end
    end

    lcdsm_timer u_refresh_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rst_value(REFRESH_ELAPSED_RST),
        .i_tick     (tick_en),
        .i_period   (r_refresh_period),
        .o_fire     (refresh_fire)
    );

    lcdsm_timer u_scan_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rst_value(SCAN_ELAPSED_RST),
        .i_tick     (tick_en),
        .i_period   (r_scan_period),
        .o_fire     (scan_fire)
    );

    lcdsm_display u_display (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (disp_ctl),
        .i_digit_index(r_s1_digit_index),
        .i_digit_word (r_s1_digit_word),
        .i_upside     (r_upside_down),
        .i_com        (r_scan_phase[2:1]),
        .o_com_byte   (com_byte)
    );

    // Advance the scan phase with every emitted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_phase <= 3'd0;
        end else if (load_out) begin
            r_scan_phase <= r_scan_phase + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // COM low drives the true segments, COM high the inverted ones.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_com   <= r_scan_phase[2:1];
            r_out_level <= r_scan_phase[0];
            r_out_seg   <= r_scan_phase[0] ? ~com_byte : com_byte;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_active_com = r_out_com;
    assign o_com_level  = r_out_level;
    assign o_segments   = r_out_seg;

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_out_valid)
        else $error("result not presented after scan fire");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !load_out)
        else $error("unread result overwritten");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_func)))
        else $error("stalled item lost");

    a_phase_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load_out |=> $stable(r_scan_phase))
        else $error("scan phase moved without a result");

    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_com_level == $past(r_scan_phase[0])))
        else $error("COM level does not follow scan phase");

endmodule

### verif/lcdsm_drive_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multiplexed LCD driver: watch the register port and both
// item channels, predict every drive item and compare it. Uses lcdsm_pkg.

module lcdsm_drive_checker
    import lcdsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_func,
    input  logic [1:0] i_digit_index,
    input  logic [4:0] i_char_code,
    input  logic       i_decimal_point,
    input  logic       i_blink,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_active_com,
    input  logic       i_com_level,
    input  logic [7:0] i_segments,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    typedef struct packed {
        logic [1:0] com;
        logic       level;
        logic [7:0] seg;
    } t_drive;

    localparam logic [7:0] UPRIGHT_GLYPHS [28] = '{
        8'hB7, 8'h22, 8'h9B, 8'hAB, 8'h2E, 8'hAD, 8'hBD, 8'h23, 8'hBF, 8'hAF,
        8'h3F, 8'hBC, 8'h95, 8'hBA, 8'h9D, 8'h1D, 8'hB5, 8'h3E, 8'hA2, 8'h94,
        8'h38, 8'hB8, 8'h1F, 8'h18, 8'h9C, 8'hB6, 8'h08, 8'h00
    };

    localparam logic [7:0] FLIPPED_GLYPHS [28] = '{
        8'hB7, 8'h14, 8'h9B, 8'h9D, 8'h3C, 8'hAD, 8'hAF, 8'h94, 8'hBF, 8'hBD,
        8'hBE, 8'h2F, 8'hA3, 8'h1F, 8'hAB, 8'hAA, 8'hA7, 8'h3E, 8'h15, 8'h23,
        8'h0E, 8'h0F, 8'hBA, 8'h0A, 8'h2B, 8'h37, 8'h08, 8'h00
    };

    // Register copies and display state.
    logic       flip;
    logic [7:0] scan_period;
    logic [7:0] refresh_period;
    logic [6:0] digit_store [4];
    logic [7:0] com_bytes [4];
    logic [2:0] blink_count;
    logic [7:0] refresh_elapsed;
    logic [7:0] scan_elapsed;
    logic [2:0] scan_phase;

    t_drive expected_drives [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void reset_model();
        flip            = 1'b0;
        scan_period     = SCAN_PERIOD_RST;
        refresh_period  = REFRESH_PERIOD_RST;
        blink_count     = 3'd0;
        refresh_elapsed = REFRESH_ELAPSED_RST;
        scan_elapsed    = SCAN_ELAPSED_RST;
        scan_phase      = 3'd0;
        for (int i = 0; i < 4; i++) begin
            digit_store[i] = 7'd0;
            com_bytes[i]   = 8'd0;
        end
        expected_drives.delete();
    endfunction

    // Segment byte of one stored digit: blanked while blinking off.
    function automatic logic [7:0] digit_segments(logic [6:0] entry);
        logic [7:0] seg;
        seg = 8'h00;
        if (!(entry[6] && blink_count > 3'd4)) begin
            if (entry[4:0] < 5'd28) begin
                seg = flip ? FLIPPED_GLYPHS[entry[4:0]] : UPRIGHT_GLYPHS[entry[4:0]];
            end
            if (entry[5]) begin
                seg = seg | 8'h40;
            end
        end
        return seg;
    endfunction

    function automatic void rebuild_com_bytes();
        int         k;
        int         j;
        int         idx;
        logic [7:0] seg;
        blink_count = blink_count + 3'd1;
        for (k = 0; k < DIGITS && k < 4; k++) begin
            idx = flip ? k : DIGITS - 1 - k;
            seg = digit_segments(digit_store[idx[1:0]]);
            for (j = 0; j < 4; j++) begin
                com_bytes[j] = {com_bytes[j][5:0], seg[1:0]};
                seg = seg >> 2;
            end
        end
    endfunction

    // Returns {fired, next count}; the count saturates at 255.
    function automatic logic [8:0] advance_count(logic [7:0] cnt, logic [7:0] period);
        logic [8:0] n;
        n = {1'b0, cnt} + 9'd1;
        if (n > 9'd255) begin
            n = 9'd255;
        end
        if (n >= {1'b0, period}) begin
            return {1'b1, 8'h00};
        end
        return {1'b0, n[7:0]};
    endfunction

    function automatic void predict_tick();
        logic [8:0] r;
        t_drive     d;
        r = advance_count(refresh_elapsed, refresh_period);
        refresh_elapsed = r[7:0];
        if (r[8]) begin
            rebuild_com_bytes();
        end
        r = advance_count(scan_elapsed, scan_period);
        scan_elapsed = r[7:0];
        if (r[8]) begin
            d.com   = scan_phase[2:1];
            d.level = scan_phase[0];
            d.seg   = scan_phase[0] ? ~com_bytes[scan_phase[2:1]] : com_bytes[scan_phase[2:1]];
            expected_drives.push_back(d);
            scan_phase = scan_phase + 3'd1;
        end
    endfunction

    function automatic void log_failure(string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_drive want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            // Compare first: a drive item never stems from an item taken this edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_drives.size() == 0) begin
                    log_failure($sformatf("%0t: unexpected drive item com=%0d level=%0d seg=%02h",
                                          $realtime, i_active_com, i_com_level, i_segments));
                end else begin
                    want = expected_drives.pop_front();
                    o_checked++;
                    if (want.com !== i_active_com || want.level !== i_com_level ||
                        want.seg !== i_segments) begin
                        log_failure($sformatf(
                            "%0t: drive mismatch com %0d/%0d level %0d/%0d seg %02h/%02h (exp/act)",
                            $realtime, want.com, i_active_com, want.level, i_com_level,
                            want.seg, i_segments));
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_UPSIDE_DOWN:    flip = i_cfg_data[0];
                    CFG_SCAN_PERIOD:    scan_period = i_cfg_data;
                    CFG_REFRESH_PERIOD: refresh_period = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_func'(i_func) == FUNC_WRITE) begin
                    if (int'(i_digit_index) < DIGITS) begin
                        digit_store[i_digit_index] = {i_blink, i_decimal_point, i_char_code};
                    end
                end else begin
                    predict_tick();
                end
            end
        end
        o_pending <= expected_drives.size();
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Top of the LCD driver testbench: clock, reset, register writes and item
// traffic with idling. Depends on lcdsm_pkg, the driver and lcdsm_drive_checker.

module testbench
    import lcdsm_pkg::*;
;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 116;
    localparam int HOLD_CYCLES  = 300;
    // Two registers between input and output; the drain wait covers them with room to spare.
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [1:0] cfg_index    = 2'd0;
    logic [7:0] cfg_data     = 8'd0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       func         = 1'b0;
    logic [1:0] digit_index  = 2'd0;
    logic [4:0] char_code    = 5'd0;
    logic       decimal_point = 1'b0;
    logic       blink        = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [1:0] active_com;
    logic       com_level;
    logic [7:0] segments;

    int fail_count;
    int pending;
    int checked;

    int items_sent     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_active     = 1'b0;
    event hold_go;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lcd_seven_segment_mux_driver dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (func),
        .i_digit_index   (digit_index),
        .i_char_code     (char_code),
        .i_decimal_point (decimal_point),
        .i_blink         (blink),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_active_com    (active_com),
        .o_com_level     (com_level),
        .o_segments      (segments)
    );

    lcdsm_drive_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (func),
        .i_digit_index   (digit_index),
        .i_char_code     (char_code),
        .i_decimal_point (decimal_point),
        .i_blink         (blink),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_active_com    (active_com),
        .i_com_level     (com_level),
        .i_segments      (segments),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Watchdog: abort a run that hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[lcd_seven_segment_mux_driver] ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or solidly while a long hold-off runs.
    always @(posedge clk) begin
        out_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Long hold-off: block the output for a fixed stretch once triggered, so
    // the driver fills both registers and pushes back on the sender.
    initial begin : long_hold
        forever begin
            @(hold_go);
            @(negedge clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    // Write one register; the caller drops the write enable.
    task automatic write_reg(t_cfg_index idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Drain the driver, then load all three registers.
    task automatic set_config(logic flip, logic [7:0] scan, logic [7:0] refresh);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // A silent tick may still sit in the pipe; let it pass.
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_UPSIDE_DOWN, {7'd0, flip});
        write_reg(CFG_SCAN_PERIOD, scan);
        write_reg(CFG_REFRESH_PERIOD, refresh);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offer one item after an optional random gap; hold it until accepted.
    task automatic send_item(t_func f, logic [1:0] idx, logic [4:0] code, logic dp, logic bl);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        digit_index   <= idx;
        char_code     <= code;
        decimal_point <= dp;
        blink         <= bl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Mostly ticks so drive items keep coming; ticks carry random fields too.
    task automatic send_random();
        t_func f;
        f = ($urandom_range(0, 99) < 60) ? FUNC_TICK : FUNC_WRITE;
        send_item(f, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(int p);
        case (p)
            0: set_config(1'b0, 8'd1, 8'd1);
            1: set_config(1'b1, 8'd0, 8'd0);      // zero periods fire on every tick
            2: set_config(1'b0, 8'd255, 8'd255);
            3: set_config(1'b1, 8'd2, 8'd3);
            default: set_config(1'($urandom_range(0, 1)), 8'($urandom_range(1, 4)),
                                8'($urandom_range(1, 8)));
        endcase
        // Idling modes: none, sender, receiver, both lightly.
        case (p % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 0 && n == 20) begin
                -> hold_go;
            end
            // Lower both periods below the running counts: each fires next tick.
            if (p == 2 && n == PHASE_ITEMS / 2) begin
                set_config(1'b0, 8'd2, 8'd1);
            end
            send_random();
        end
    endtask

    initial begin : stimulus
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Touch the spare register index once; it must change nothing.
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
        set_config(1'b0, 8'd1, 8'd1);

        // Directed: blank and out-of-range glyph codes, points and blinking,
        // then a full blink cycle and all eight scan phases.
        send_item(FUNC_WRITE, 2'd0, 5'd0, 1'b0, 1'b0);
        send_item(FUNC_WRITE, 2'd1, 5'd27, 1'b1, 1'b0);
        send_item(FUNC_WRITE, 2'd2, 5'd31, 1'b1, 1'b1);
        send_item(FUNC_WRITE, 2'd3, 5'd28, 1'b0, 1'b1);
        for (int i = 0; i < 8; i++) begin
            send_item(FUNC_TICK, 2'(i), 5'(31 - i), 1'(i), 1'(i >> 1));
        end
        send_item(FUNC_WRITE, 2'd3, 5'd9, 1'b1, 1'b1);
        send_item(FUNC_WRITE, 2'd2, 5'd26, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) begin
            send_item(FUNC_TICK, 2'd3, 5'd0, 1'b0, 1'b1);
        end

        for (int p = 0; p < PHASES; p++) begin
            run_phase(p);
        end

        // Drop valid, wait for the last drive item, then let the pipe settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d register settings, checked %0d drive items;",
                 items_sent, settings_used, checked);
        $display("covered zero and full-scale periods, both orientations and a long hold-off.");
        if (fail_count == 0) begin
            $display("[lcd_seven_segment_mux_driver] OK");
        end else begin
            $display("[lcd_seven_segment_mux_driver] ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/lcdsm_pkg.sv
design/lcdsm_glyph.sv
design/lcdsm_timer.sv
design/lcdsm_display.sv
design/lcd_seven_segment_mux_driver.sv
verif/lcdsm_drive_checker.sv
verif/testbench.sv
